>>> design/sut_pkg.sv
// Shared types and constants for the scatter update table.
`default_nettype none
package sut_pkg;
   localparam int DEF_MAX_ROWS      = 256;
   localparam int DEF_MAX_ROW_WIDTH = 16;
   localparam int DEF_VALUE_BITS    = 32;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 32;
   localparam int COL_W      = 4;
   localparam int UVAL_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_W    = 32;
   localparam int MODE_W     = 2;
   localparam int ROWCNT_W   = 9;
   localparam int ROWWID_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int ACT_W      = 3;

   localparam logic [ROWCNT_W-1:0] ROWCNT_RESET = ROWCNT_W'(256);
   localparam logic [ROWWID_W-1:0] ROWWID_RESET = ROWWID_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPDATE_MODE = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_ROW_WIDTH   = 2'd2
   } csr_idx_type;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_SCATTER = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_ASSIGN = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_SUB    = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_APPLIED   = 2'd0,
      STATUS_IGNORED   = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_IGNORE = 3'd0,
      ACT_ASSIGN = 3'd1,
      ACT_ADD    = 3'd2,
      ACT_SUB    = 3'd3,
      ACT_READ   = 3'd4
   } act_type;
endpackage
`default_nettype wire

>>> design/scatter_update_table.sv
// Scatter update table top level: queue ports, front end, command queue, back end.
// A pushed beat is poppable after the command queue, back-end EXEC and result queue.
// The back end takes no new beat until its read then write of the table RAM is done.
// Command queue holds 4 beats, result queue 2; each side stalls on its own.
// Reset (synchronous, high) empties the queues, mode 0, row_count 256, row_width 16.
// Table contents are undefined after reset until written; there is no clearing pass.
`default_nettype none
module scatter_update_table
   import sut_pkg::*;
#(
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
   parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic        [OP_W-1:0]       req_op,
   input  wire logic signed [ROW_W-1:0]      req_row_index,
   input  wire logic        [COL_W-1:0]      req_column,
   input  wire logic signed [UVAL_W-1:0]     req_update_value,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic             [STATUS_W-1:0]   rsp_status,
   output logic signed      [ENTRY_W-1:0]    rsp_entry_value,
   input  wire logic                         csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata
);
   localparam int DEPTH   = MAX_ROWS * MAX_ROW_WIDTH;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMD_W   = ACT_W + ADDR_W + VALUE_BITS;
   localparam int RES_W   = STATUS_W + ENTRY_W;

   act_type               front_kind, back_kind;
   logic [ADDR_W-1:0]     front_addr;
   logic [VALUE_BITS-1:0] front_value;
   logic [CMD_W-1:0]      cmd_rdata;
   logic                  cmd_empty, cmd_pop;
   logic                  res_push, res_full;
   status_type            res_status;
   logic [ENTRY_W-1:0]    res_value;
   logic [RES_W-1:0]      res_rdata;

   sut_front #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .VALUE_BITS    (VALUE_BITS),
      .ADDR_W        (ADDR_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_op),
      .req_row_index    (req_row_index),
      .req_column       (req_column),
      .req_update_value (req_update_value),
      .cmd_kind         (front_kind),
      .cmd_addr         (front_addr),
      .cmd_value        (front_value)
   );

   sut_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({front_kind, front_addr, front_value}),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty)
   );

   assign back_kind = act_type'(cmd_rdata[CMD_W-1 -: ACT_W]);

   sut_back #(
      .VALUE_BITS (VALUE_BITS),
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_kind   (back_kind),
      .cmd_addr   (cmd_rdata[VALUE_BITS +: ADDR_W]),
      .cmd_value  (cmd_rdata[VALUE_BITS-1:0]),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_status (res_status),
      .res_value  (res_value)
   );

   sut_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data ({res_status, res_value}),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_status      = res_rdata[RES_W-1 -: STATUS_W];
   assign rsp_entry_value = res_rdata[ENTRY_W-1:0];
endmodule
`default_nettype wire

>>> design/sut_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sut_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> design/sut_fifo.sv
// Small show-ahead queue used between the front end, back end and result port.
`default_nettype none
module sut_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

>>> design/sut_front.sv
// Front end: config registers, range check, flat address and action decode.
`default_nettype none
module sut_front
   import sut_pkg::*;
#(
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
   parameter int VALUE_BITS    = DEF_VALUE_BITS,
   parameter int ADDR_W        = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic        [OP_W-1:0]       req_op,
   input  wire logic signed [ROW_W-1:0]      req_row_index,
   input  wire logic        [COL_W-1:0]      req_column,
   input  wire logic signed [UVAL_W-1:0]     req_update_value,
   output act_type                           cmd_kind,
   output logic             [ADDR_W-1:0]     cmd_addr,
   output logic             [VALUE_BITS-1:0] cmd_value
);
   localparam int PROD_W = ROWCNT_W + ROWWID_W + 1;

   logic [MODE_W-1:0]   mode_ff;
   logic [ROWCNT_W-1:0] row_count_ff;
   logic [ROWWID_W-1:0] row_width_ff;
   logic [ROWCNT_W-1:0] rows_lim;
   logic [ROWWID_W-1:0] width_lim;
   logic                row_ok, col_ok;
   logic [PROD_W-1:0]   flat_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_W'(MODE_ASSIGN);
         row_count_ff <= ROWCNT_RESET;
         row_width_ff <= ROWWID_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_UPDATE_MODE: mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_ROW_COUNT:   row_count_ff <= csr_wdata[ROWCNT_W-1:0];
            CSR_ROW_WIDTH:   row_width_ff <= csr_wdata[ROWWID_W-1:0];
            default: ;
         endcase
      end
   end

   // bounds clamp to the table geometry
   always_comb begin
      rows_lim  = row_count_ff;
      width_lim = row_width_ff;
      if (32'(row_count_ff) > MAX_ROWS) begin
         rows_lim = ROWCNT_W'(MAX_ROWS);
      end
      if (32'(row_width_ff) > MAX_ROW_WIDTH) begin
         width_lim = ROWWID_W'(MAX_ROW_WIDTH);
      end
   end

   assign row_ok    = !req_row_index[ROW_W-1] &&
                      ({1'b0, req_row_index[ROW_W-2:0]} < ROW_W'(rows_lim));
   assign col_ok    = (ROWWID_W'(req_column) < width_lim);
   assign flat_addr = PROD_W'(req_row_index[ROWCNT_W-1:0]) * PROD_W'(width_lim)
                      + PROD_W'(req_column);
   assign cmd_addr  = ADDR_W'(flat_addr);
   assign cmd_value = VALUE_BITS'(req_update_value);

   always_comb begin
      cmd_kind = ACT_IGNORE;
      if (row_ok && col_ok) begin
         unique case (op_type'(req_op))
            OP_WRITE: cmd_kind = ACT_ASSIGN;
            OP_SCATTER: begin
               unique case (mode_type'(mode_ff))
                  MODE_ASSIGN: cmd_kind = ACT_ASSIGN;
                  MODE_ADD:    cmd_kind = ACT_ADD;
                  MODE_SUB:    cmd_kind = ACT_SUB;
                  default:     cmd_kind = ACT_IGNORE;
               endcase
            end
            OP_READ: cmd_kind = ACT_READ;
            default: cmd_kind = ACT_IGNORE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> design/sut_back.sv
// Back end: read, assign and saturating add/sub read-modify-write of the parameter table.
`default_nettype none
module sut_back
   import sut_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int DEPTH      = DEF_MAX_ROWS * DEF_MAX_ROW_WIDTH,
   parameter int ADDR_W     = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_empty,
   output logic                          cmd_pop,
   input  act_type                       cmd_kind,
   input  wire logic [ADDR_W-1:0]        cmd_addr,
   input  wire logic [VALUE_BITS-1:0]    cmd_value,
   input  wire logic                     res_full,
   output logic                          res_push,
   output status_type                    res_status,
   output logic      [ENTRY_W-1:0]       res_value
);
   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type             state_ff, state_in;
   act_type               kind_ff, kind_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] rd_data;
   logic [VALUE_BITS-1:0] sum, new_entry;
   logic                  is_sub, sa, sb, sr, ovf, wr_en;

   sut_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH),
      .AW    (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (new_entry),
      .rd_en   (cmd_pop),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty && !res_full;
   assign res_push = (state_ff == ST_EXEC);

   assign is_sub = (kind_ff == ACT_SUB);
   assign sum    = is_sub ? rd_data - value_ff : rd_data + value_ff;
   assign sa     = rd_data[VALUE_BITS-1];
   assign sb     = value_ff[VALUE_BITS-1];
   assign sr     = sum[VALUE_BITS-1];
   assign ovf    = is_sub ? ((sa != sb) && (sr != sa)) : ((sa == sb) && (sr != sa));

   always_comb begin
      new_entry  = '0;
      wr_en      = 1'b0;
      res_status = STATUS_APPLIED;
      case (kind_ff) inside
         ACT_ASSIGN: begin
            new_entry = value_ff;
            wr_en     = res_push;
         end
         ACT_ADD, ACT_SUB: begin
            new_entry = ovf ? {sa, {(VALUE_BITS-1){~sa}}} : sum;
            wr_en     = res_push;
            if (ovf) begin
               res_status = STATUS_SATURATED;
            end
         end
         ACT_READ: new_entry = rd_data;
         default:  res_status = STATUS_IGNORED;
      endcase
   end

   assign res_value = ENTRY_W'(new_entry);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      value_in = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               state_in = ST_EXEC;
               kind_in  = cmd_kind;
               addr_in  = cmd_addr;
               value_in = cmd_value;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= ACT_IGNORE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
      addr_ff  <= addr_in;
      value_ff <= value_in;
   end
endmodule
`default_nettype wire
